/* rtl/mio_pkg.sv */
// Package for the monitor I/O block: payload structs, port and kind codes,
// USART command bits and the control/status structs of the serial port unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mio_pkg;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   localparam logic [3:0] PORT_INT       = 4'd0;
   localparam logic [3:0] PORT_TTY_DATA  = 4'd1;
   localparam logic [3:0] PORT_TTY_STAT  = 4'd2;
   localparam logic [3:0] PORT_CRT_DATA  = 4'd3;
   localparam logic [3:0] PORT_CRT_STAT  = 4'd4;
   localparam logic [3:0] PORT_TAPE_DATA = 4'd5;
   localparam logic [3:0] PORT_TAPE_STAT = 4'd6;
   localparam logic [3:0] PORT_LPT_DATA  = 4'd7;
   localparam logic [3:0] PORT_LPT_STAT  = 4'd8;

   localparam logic [2:0] CFG_TTY_UPPER = 3'd0;
   localparam logic [2:0] CFG_TTY_STRIP = 3'd1;
   localparam logic [2:0] CFG_TTY_SKIP  = 3'd2;
   localparam logic [2:0] CFG_CRT_UPPER = 3'd3;
   localparam logic [2:0] CFG_CRT_STRIP = 3'd4;
   localparam logic [2:0] CFG_CRT_SKIP  = 3'd5;

   localparam logic [1:0] TARGET_TTY   = 2'd0;
   localparam logic [1:0] TARGET_CRT   = 2'd1;
   localparam logic [1:0] TARGET_PUNCH = 2'd2;
   localparam logic [1:0] TARGET_LPT   = 2'd3;

   // interrupt flag bit positions
   localparam int INT_TTYO   = 0;
   localparam int INT_TTYI   = 1;
   localparam int INT_PTP    = 2;
   localparam int INT_PTR    = 3;
   localparam int INT_CRTO   = 4;
   localparam int INT_CRTI   = 5;
   localparam int INT_LPT    = 6;
   localparam int INT_ENABLE = 7;

   // USART command bits
   localparam int CMD_TXEN  = 0;
   localparam int CMD_RXEN  = 2;
   localparam int CMD_RESET = 6;
   localparam logic [5:0] CMD_KEEP = 6'h37;

   localparam logic [7:0] STAT_BASE   = 8'h80;
   localparam logic [7:0] STAT_TX     = 8'h05;
   localparam logic [7:0] STAT_RX     = 8'h02;
   localparam logic [7:0] STRIP_MASK  = 8'h7f;
   localparam logic [7:0] BYTE_NUL    = 8'h00;
   localparam logic [7:0] BYTE_CR     = 8'h0d;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] port;
      logic [7:0] write_byte;
      logic [7:0] host_byte;
      logic       tty_link;
      logic       tty_rx_avail;
      logic       crt_rx_avail;
      logic       tape_link;
      logic       tape_rx_avail;
      logic       tape_tx_space;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       irq;
      logic       send_valid;
      logic [1:0] send_target;
      logic [7:0] send_byte;
   } rsp_payload_type;

   typedef struct packed {
      logic       read;
      logic       write_data;
      logic       write_cmd;
      logic       tick;
      logic       link;
      logic       rx_avail;
      logic       upper;
      logic       strip;
      logic       skip;
      logic [7:0] host_byte;
      logic [7:0] write_byte;
   } usart_ctl_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic [7:0] status_byte;
      logic       send_valid;
      logic [7:0] send_byte;
      logic       clr_in;
      logic       clr_out;
      logic       set_in;
      logic       set_out;
   } usart_stat_type;

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic is_lower;
      is_lower = c inside {[8'h61:8'h7a]};
      return is_lower ? c - CASE_OFFSET : c;
   endfunction

endpackage

`default_nettype wire

/* rtl/mio_stream_if.sv */
// Valid/ready channel carrying one payload struct per transaction.
// Payload type is set by the instantiating level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mio_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/mio_usart.sv */
// One USART-like serial port: mode/command handling, ready flags, data path.
// Depends on mio_pkg; strobes in ctl are already qualified by the transaction.
`timescale 1ns / 1ps
`default_nettype none

module mio_usart
   import mio_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire usart_ctl_type  ctl,
   output usart_stat_type      stat
);

   logic       mode_seen_ff, mode_seen_in;
   logic [5:0] command_ff, command_in;
   logic       tx_ready_ff, tx_ready_in;
   logic       rx_ready_ff, rx_ready_in;
   logic [7:0] last_rx_ff, last_rx_in;

   logic       rx_ok;
   logic       tx_ok;
   logic [7:0] rx_byte;
   logic [5:0] new_cmd;

   always_comb begin
      mode_seen_in = mode_seen_ff;
      command_in   = command_ff;
      tx_ready_in  = tx_ready_ff;
      rx_ready_in  = rx_ready_ff;
      last_rx_in   = last_rx_ff;
      stat         = '0;

      rx_ok   = command_ff[CMD_RXEN] && rx_ready_ff;
      tx_ok   = command_ff[CMD_TXEN] && tx_ready_ff;
      rx_byte = ctl.upper ? to_upper(ctl.host_byte) : ctl.host_byte;
      new_cmd = ctl.write_byte[CMD_RESET] ? '0 : ctl.write_byte[5:0] & CMD_KEEP;

      stat.status_byte = STAT_BASE | (tx_ok ? STAT_TX : '0) | (rx_ok ? STAT_RX : '0);
      stat.read_byte   = last_rx_ff;

      if (ctl.read && rx_ok) begin
         if (ctl.link) begin
            last_rx_in     = rx_byte;
            stat.read_byte = rx_byte;
         end
         rx_ready_in = 1'b0;
         stat.clr_in = 1'b1;
      end

      if (ctl.write_data && tx_ok) begin
         stat.send_valid = ctl.link && !(ctl.skip && ctl.write_byte == BYTE_NUL);
         stat.send_byte  = ctl.strip ? ctl.write_byte & STRIP_MASK : ctl.write_byte;
         tx_ready_in     = 1'b0;
         stat.clr_out    = 1'b1;
      end

      if (ctl.write_cmd) begin
         if (!mode_seen_ff) begin
            mode_seen_in = 1'b1;
         end else begin
            mode_seen_in = !ctl.write_byte[CMD_RESET];
            command_in   = new_cmd;
            if (!new_cmd[CMD_RXEN] && rx_ready_ff) begin
               rx_ready_in = 1'b0;
               stat.clr_in = 1'b1;
            end
            if (!new_cmd[CMD_TXEN] && tx_ready_ff) begin
               tx_ready_in  = 1'b0;
               stat.clr_out = 1'b1;
            end
         end
      end

      if (ctl.tick) begin
         if (command_ff[CMD_RXEN] && !rx_ready_ff && ctl.rx_avail) begin
            rx_ready_in = 1'b1;
            stat.set_in = 1'b1;
         end
         if (command_ff[CMD_TXEN] && !tx_ready_ff) begin
            tx_ready_in  = 1'b1;
            stat.set_out = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_seen_ff <= 1'b0;
         command_ff   <= '0;
         tx_ready_ff  <= 1'b0;
         rx_ready_ff  <= 1'b0;
         last_rx_ff   <= '0;
      end else begin
         mode_seen_ff <= mode_seen_in;
         command_ff   <= command_in;
         tx_ready_ff  <= tx_ready_in;
         rx_ready_ff  <= rx_ready_in;
         last_rx_ff   <= last_rx_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/monitor_io_ports_with_interrupts.sv */
// Top level of the monitor I/O block: bus/tick decode, tape and printer ports,
// interrupt flags, result register. Depends on mio_pkg, mio_stream_if, mio_usart.
//
//   channel  dir  handshake      content
//   req_ch   in   valid/ready    bus read, bus write or tick
//   rsp_ch   out  valid/ready    read data, irq, emitted byte
//   csr_*    in   write enable   six 1-bit option registers
//
// One transaction per cycle: decode, state update and the result are one level
// of logic from the request to the result register. The request is taken
// whenever the result register is empty or being drained in the same cycle.
// Synchronous reset clears all port state, interrupt flags and options.
`timescale 1ns / 1ps
`default_nettype none

module monitor_io_ports_with_interrupts
   import mio_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   mio_stream_if.sink       req_ch,
   mio_stream_if.source     rsp_ch,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [0:0]  csr_write_data
);

   req_payload_type req;
   logic            req_fire;
   logic            is_read, is_write, is_tick;

   logic [5:0]      cfg_ff;

   logic [7:0]      int_flags_ff, int_flags_in;
   logic            reader_ready_ff, reader_ready_in;
   logic            punch_ready_ff, punch_ready_in;
   logic [7:0]      reader_last_ff, reader_last_in;
   logic            printer_ready_ff, printer_ready_in;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   usart_ctl_type   tty_ctl, crt_ctl;
   usart_stat_type  tty_stat, crt_stat;

   logic [7:0]      int_clr, int_set;
   logic [7:0]      lpt_byte;

   assign req           = req_ch.payload;
   assign req_ch.ready  = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign is_read       = req_fire && req.kind == KIND_READ;
   assign is_write      = req_fire && req.kind == KIND_WRITE;
   assign is_tick       = req_fire && req.kind == KIND_TICK;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   always_comb begin
      tty_ctl            = '0;
      tty_ctl.read       = is_read && req.port == PORT_TTY_DATA;
      tty_ctl.write_data = is_write && req.port == PORT_TTY_DATA;
      tty_ctl.write_cmd  = is_write && req.port == PORT_TTY_STAT;
      tty_ctl.tick       = is_tick && req.tty_link;
      tty_ctl.link       = req.tty_link;
      tty_ctl.rx_avail   = req.tty_rx_avail;
      tty_ctl.upper      = cfg_ff[CFG_TTY_UPPER];
      tty_ctl.strip      = cfg_ff[CFG_TTY_STRIP];
      tty_ctl.skip       = cfg_ff[CFG_TTY_SKIP];
      tty_ctl.host_byte  = req.host_byte;
      tty_ctl.write_byte = req.write_byte;

      crt_ctl            = '0;
      crt_ctl.read       = is_read && req.port == PORT_CRT_DATA;
      crt_ctl.write_data = is_write && req.port == PORT_CRT_DATA;
      crt_ctl.write_cmd  = is_write && req.port == PORT_CRT_STAT;
      crt_ctl.tick       = is_tick;
      crt_ctl.link       = 1'b1;
      crt_ctl.rx_avail   = req.crt_rx_avail;
      crt_ctl.upper      = cfg_ff[CFG_CRT_UPPER];
      crt_ctl.strip      = cfg_ff[CFG_CRT_STRIP];
      crt_ctl.skip       = cfg_ff[CFG_CRT_SKIP];
      crt_ctl.host_byte  = req.host_byte;
      crt_ctl.write_byte = req.write_byte;
   end

   mio_usart u_tty (
      .clock (clock),
      .reset (reset),
      .ctl   (tty_ctl),
      .stat  (tty_stat)
   );

   mio_usart u_crt (
      .clock (clock),
      .reset (reset),
      .ctl   (crt_ctl),
      .stat  (crt_stat)
   );

   assign lpt_byte = ~req.write_byte;

   always_comb begin
      reader_ready_in  = reader_ready_ff;
      punch_ready_in   = punch_ready_ff;
      reader_last_in   = reader_last_ff;
      printer_ready_in = printer_ready_ff;
      rsp_in           = '0;

      int_clr = '0;
      int_set = '0;
      int_clr[INT_TTYI] = tty_stat.clr_in;
      int_clr[INT_TTYO] = tty_stat.clr_out;
      int_clr[INT_CRTI] = crt_stat.clr_in;
      int_clr[INT_CRTO] = crt_stat.clr_out;
      int_set[INT_TTYI] = tty_stat.set_in;
      int_set[INT_TTYO] = tty_stat.set_out;
      int_set[INT_CRTI] = crt_stat.set_in;
      int_set[INT_CRTO] = crt_stat.set_out;

      if (is_read) begin
         case (req.port)
            PORT_INT:       rsp_in.read_byte = {1'b0, int_flags_ff[6:0]};
            PORT_TTY_DATA:  rsp_in.read_byte = tty_stat.read_byte;
            PORT_TTY_STAT:  rsp_in.read_byte = tty_stat.status_byte;
            PORT_CRT_DATA:  rsp_in.read_byte = crt_stat.read_byte;
            PORT_CRT_STAT:  rsp_in.read_byte = crt_stat.status_byte;
            PORT_TAPE_DATA: begin
               if (reader_ready_ff) begin
                  if (req.tape_link) begin
                     reader_last_in = req.host_byte;
                  end
                  reader_ready_in  = 1'b0;
                  int_clr[INT_PTR] = 1'b1;
               end
               rsp_in.read_byte = reader_last_in;
            end
            PORT_TAPE_STAT: rsp_in.read_byte = {5'd0, punch_ready_ff, 1'b0, reader_ready_ff};
            PORT_LPT_STAT:  rsp_in.read_byte = {7'd0, printer_ready_ff};
            default:        rsp_in.read_byte = '0;
         endcase
      end

      if (is_write) begin
         case (req.port)
            PORT_TTY_DATA: begin
               rsp_in.send_valid  = tty_stat.send_valid;
               rsp_in.send_target = TARGET_TTY;
               rsp_in.send_byte   = tty_stat.send_byte;
            end
            PORT_CRT_DATA: begin
               rsp_in.send_valid  = crt_stat.send_valid;
               rsp_in.send_target = TARGET_CRT;
               rsp_in.send_byte   = crt_stat.send_byte;
            end
            PORT_TAPE_DATA: begin
               if (punch_ready_ff) begin
                  rsp_in.send_valid  = req.tape_link;
                  rsp_in.send_target = TARGET_PUNCH;
                  rsp_in.send_byte   = req.write_byte;
                  punch_ready_in     = 1'b0;
                  int_clr[INT_PTP]   = 1'b1;
               end
            end
            PORT_LPT_DATA: begin
               if (printer_ready_ff) begin
                  rsp_in.send_valid  = lpt_byte != BYTE_CR && lpt_byte != BYTE_NUL;
                  rsp_in.send_target = TARGET_LPT;
                  rsp_in.send_byte   = lpt_byte;
                  printer_ready_in   = 1'b0;
                  int_clr[INT_LPT]   = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (is_tick) begin
         if (req.tape_link) begin
            if (req.tape_rx_avail && !reader_ready_ff) begin
               reader_ready_in  = 1'b1;
               int_set[INT_PTR] = 1'b1;
            end
            if (req.tape_tx_space && !punch_ready_ff) begin
               punch_ready_in   = 1'b1;
               int_set[INT_PTP] = 1'b1;
            end
         end else begin
            reader_ready_in  = 1'b0;
            punch_ready_in   = 1'b0;
            int_clr[INT_PTR] = reader_ready_ff;
            int_clr[INT_PTP] = punch_ready_ff;
         end
         if (!printer_ready_ff) begin
            printer_ready_in = 1'b1;
            int_set[INT_LPT] = 1'b1;
         end
      end

      if (is_write && req.port == PORT_INT) begin
         int_flags_in = {req.write_byte[7], int_flags_ff[6:0] & ~req.write_byte[6:0]};
      end else begin
         int_flags_in = (int_flags_ff & ~int_clr) | int_set;
      end

      if (!rsp_in.send_valid) begin
         rsp_in.send_target = TARGET_TTY;
         rsp_in.send_byte   = '0;
      end
      rsp_in.irq = int_flags_in[INT_ENABLE] && |int_flags_in[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CFG_TTY_UPPER: cfg_ff[CFG_TTY_UPPER] <= csr_write_data[0];
            CFG_TTY_STRIP: cfg_ff[CFG_TTY_STRIP] <= csr_write_data[0];
            CFG_TTY_SKIP:  cfg_ff[CFG_TTY_SKIP]  <= csr_write_data[0];
            CFG_CRT_UPPER: cfg_ff[CFG_CRT_UPPER] <= csr_write_data[0];
            CFG_CRT_STRIP: cfg_ff[CFG_CRT_STRIP] <= csr_write_data[0];
            CFG_CRT_SKIP:  cfg_ff[CFG_CRT_SKIP]  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_flags_ff     <= '0;
         reader_ready_ff  <= 1'b0;
         punch_ready_ff   <= 1'b0;
         reader_last_ff   <= '0;
         printer_ready_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         int_flags_ff     <= int_flags_in;
         reader_ready_ff  <= reader_ready_in;
         punch_ready_ff   <= punch_ready_in;
         reader_last_ff   <= reader_last_in;
         printer_ready_ff <= printer_ready_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // irq in a pending result always matches the current interrupt flags
   a_irq_tracks_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.irq == (int_flags_ff[INT_ENABLE] && |int_flags_ff[6:0]))
      else $error("irq in result disagrees with interrupt flags");

   // a tick always leaves the printer ready
   a_tick_printer: assert property (@(posedge clock) disable iff (reset)
      is_tick |=> printer_ready_ff)
      else $error("printer not ready after tick");

   // printer request is never pending without the printer being ready
   a_lpt_request: assert property (@(posedge clock) disable iff (reset)
      int_flags_ff[INT_LPT] |-> printer_ready_ff)
      else $error("printer request without printer ready");

   // an idle result slot is never left empty while a request waits
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && req_ch.valid) |=> rsp_valid_ff)
      else $error("request not taken while result slot empty");

endmodule

`default_nettype wire

/* dv/monitor_io_ports_with_interrupts_test.sv */
// Self-checking testbench for monitor_io_ports_with_interrupts: a directed table, then random
// bus reads, writes and ticks under several option settings, each checked against a local model.
// Depends on mio_pkg, mio_stream_if and the block itself.
`timescale 1ns / 1ps

module monitor_io_ports_with_interrupts_test;
   import mio_pkg::*;

   localparam logic [1:0] KIND_NONE        = 2'd3;
   localparam logic [7:0] REQUEST_MASK     = 8'h7f;
   localparam logic [7:0] LOWER_A          = 8'h61;
   localparam logic [7:0] LOWER_Z          = 8'h7a;
   localparam logic [7:0] TAPE_STAT_READER = 8'h01;
   localparam logic [7:0] TAPE_STAT_PUNCH  = 8'h04;
   localparam logic [7:0] LPT_STAT_READY   = 8'h01;
   // {tty_link, tty_rx_avail, crt_rx_avail, tape_link, tape_rx_avail, tape_tx_space}
   localparam logic [5:0] LINKS_ALL        = 6'b111111;
   localparam logic [5:0] LINKS_NONE       = 6'b000000;
   localparam logic [5:0] LINKS_HOST       = 6'b100100;
   localparam int OPTION_COUNT     = 6;
   localparam int PHASE_COUNT      = 5;
   localparam int ITEMS_PER_PHASE  = 305;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int STALL_LIMIT      = 2000;

   typedef struct packed {
      logic       mode_seen;
      logic [5:0] command;
      logic       tx_ready;
      logic       rx_ready;
      logic [7:0] last_rx;
      logic       upper;
      logic       strip;
      logic       skip;
   } usart_model_type;

   typedef struct packed {
      req_payload_type req;
      logic            pinned;
      rsp_payload_type rsp;
   } stimulus_row_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [0:0]  csr_write_data;

   mio_stream_if #(.payload_type(req_payload_type)) req_ch ();
   mio_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   monitor_io_ports_with_interrupts dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // model state
   logic [7:0]      exp_int_flags;
   usart_model_type tty_st;
   usart_model_type crt_st;
   logic            reader_rdy;
   logic            punch_rdy;
   logic            printer_rdy;
   logic [7:0]      reader_byte;

   rsp_payload_type  expected_q[$];
   stimulus_row_type directed_rows[$];
   logic             pinned_flag;
   rsp_payload_type  pinned_rsp;
   int               failures;
   int               stall_cycles;
   logic             sender_idling;
   logic             receiver_idling;
   logic             long_hold_pending;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [7:0] usart_status(input usart_model_type s);
      logic [7:0] v;
      v = STAT_BASE;
      if (s.command[CMD_TXEN] && s.tx_ready) v = v | STAT_TX;
      if (s.command[CMD_RXEN] && s.rx_ready) v = v | STAT_RX;
      return v;
   endfunction

   function automatic void usart_command(inout usart_model_type s, input logic [7:0] d,
                                         input int in_bit, input int out_bit);
      if (!s.mode_seen) begin
         s.mode_seen = 1'b1;
         return;
      end
      if (d[CMD_RESET]) begin
         s.mode_seen = 1'b0;
         s.command = '0;
      end else begin
         s.command = d[5:0] & CMD_KEEP;
      end
      if (!s.command[CMD_RXEN] && s.rx_ready) begin
         s.rx_ready = 1'b0;
         exp_int_flags[in_bit] = 1'b0;
      end
      if (!s.command[CMD_TXEN] && s.tx_ready) begin
         s.tx_ready = 1'b0;
         exp_int_flags[out_bit] = 1'b0;
      end
   endfunction

   function automatic logic [7:0] usart_data_read(inout usart_model_type s, input logic link,
                                                  input logic [7:0] host, input int req_bit);
      logic [7:0] d;
      if (!s.command[CMD_RXEN] || !s.rx_ready) return s.last_rx;
      if (link) begin
         d = (s.upper && host >= LOWER_A && host <= LOWER_Z) ? host - CASE_OFFSET : host;
         s.last_rx = d;
      end else begin
         d = s.last_rx;
      end
      s.rx_ready = 1'b0;
      exp_int_flags[req_bit] = 1'b0;
      return d;
   endfunction

   function automatic void usart_data_write(inout usart_model_type s, input logic link,
                                            input logic [7:0] d, input int req_bit,
                                            output logic sent, output logic [7:0] b);
      sent = 1'b0;
      b = '0;
      if (!s.command[CMD_TXEN] || !s.tx_ready) return;
      if (link && !(s.skip && d == BYTE_NUL)) begin
         b = s.strip ? d & STRIP_MASK : d;
         sent = 1'b1;
      end
      s.tx_ready = 1'b0;
      exp_int_flags[req_bit] = 1'b0;
   endfunction

   function automatic void usart_tick(inout usart_model_type s, input logic rx_avail,
                                      input int in_bit, input int out_bit);
      if (s.command[CMD_RXEN] && !s.rx_ready && rx_avail) begin
         s.rx_ready = 1'b1;
         exp_int_flags[in_bit] = 1'b1;
      end
      if (s.command[CMD_TXEN] && !s.tx_ready) begin
         s.tx_ready = 1'b1;
         exp_int_flags[out_bit] = 1'b1;
      end
   endfunction

   function automatic rsp_payload_type predict_response(input req_payload_type r);
      rsp_payload_type o;
      logic            sent;
      logic [7:0]      b;
      logic [7:0]      c;
      o = '0;
      sent = 1'b0;
      b = '0;
      case (r.kind)
         KIND_READ: begin
            case (r.port)
               PORT_INT: o.read_byte = exp_int_flags & REQUEST_MASK;
               PORT_TTY_DATA:
                  o.read_byte = usart_data_read(tty_st, r.tty_link, r.host_byte, INT_TTYI);
               PORT_TTY_STAT: o.read_byte = usart_status(tty_st);
               PORT_CRT_DATA:
                  o.read_byte = usart_data_read(crt_st, 1'b1, r.host_byte, INT_CRTI);
               PORT_CRT_STAT: o.read_byte = usart_status(crt_st);
               PORT_TAPE_DATA: begin
                  if (reader_rdy) begin
                     if (r.tape_link) reader_byte = r.host_byte;
                     reader_rdy = 1'b0;
                     exp_int_flags[INT_PTR] = 1'b0;
                  end
                  o.read_byte = reader_byte;
               end
               PORT_TAPE_STAT: begin
                  if (reader_rdy) o.read_byte = o.read_byte | TAPE_STAT_READER;
                  if (punch_rdy) o.read_byte = o.read_byte | TAPE_STAT_PUNCH;
               end
               PORT_LPT_STAT: if (printer_rdy) o.read_byte = LPT_STAT_READY;
               default: ;
            endcase
         end
         KIND_WRITE: begin
            case (r.port)
               PORT_INT: exp_int_flags = (r.write_byte & ~REQUEST_MASK)
                                       | (exp_int_flags & ~r.write_byte & REQUEST_MASK);
               PORT_TTY_DATA: begin
                  usart_data_write(tty_st, r.tty_link, r.write_byte, INT_TTYO, sent, b);
                  o.send_target = TARGET_TTY;
               end
               PORT_TTY_STAT: usart_command(tty_st, r.write_byte, INT_TTYI, INT_TTYO);
               PORT_CRT_DATA: begin
                  usart_data_write(crt_st, 1'b1, r.write_byte, INT_CRTO, sent, b);
                  o.send_target = TARGET_CRT;
               end
               PORT_CRT_STAT: usart_command(crt_st, r.write_byte, INT_CRTI, INT_CRTO);
               PORT_TAPE_DATA: begin
                  if (punch_rdy) begin
                     if (r.tape_link) begin
                        sent = 1'b1;
                        b = r.write_byte;
                     end
                     o.send_target = TARGET_PUNCH;
                     punch_rdy = 1'b0;
                     exp_int_flags[INT_PTP] = 1'b0;
                  end
               end
               PORT_LPT_DATA: begin
                  if (printer_rdy) begin
                     c = ~r.write_byte;
                     if (c != BYTE_CR && c != BYTE_NUL) begin
                        sent = 1'b1;
                        b = c;
                     end
                     o.send_target = TARGET_LPT;
                     printer_rdy = 1'b0;
                     exp_int_flags[INT_LPT] = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         KIND_TICK: begin
            if (r.tty_link) usart_tick(tty_st, r.tty_rx_avail, INT_TTYI, INT_TTYO);
            usart_tick(crt_st, r.crt_rx_avail, INT_CRTI, INT_CRTO);
            if (r.tape_link) begin
               if (r.tape_rx_avail && !reader_rdy) begin
                  reader_rdy = 1'b1;
                  exp_int_flags[INT_PTR] = 1'b1;
               end
               if (r.tape_tx_space && !punch_rdy) begin
                  punch_rdy = 1'b1;
                  exp_int_flags[INT_PTP] = 1'b1;
               end
            end else begin
               if (reader_rdy) begin
                  reader_rdy = 1'b0;
                  exp_int_flags[INT_PTR] = 1'b0;
               end
               if (punch_rdy) begin
                  punch_rdy = 1'b0;
                  exp_int_flags[INT_PTP] = 1'b0;
               end
            end
            if (!printer_rdy) begin
               printer_rdy = 1'b1;
               exp_int_flags[INT_LPT] = 1'b1;
            end
         end
         default: ;
      endcase
      if (!sent) begin
         b = '0;
         o.send_target = TARGET_TTY;
      end
      o.send_valid = sent;
      o.send_byte = b;
      o.irq = exp_int_flags[INT_ENABLE] && (|(exp_int_flags & REQUEST_MASK));
      return o;
   endfunction

   function automatic rsp_payload_type rsp_of(input logic [7:0] rd, input logic irq,
                                              input logic sv, input logic [1:0] tgt,
                                              input logic [7:0] sb);
      rsp_payload_type o;
      o.read_byte = rd;
      o.irq = irq;
      o.send_valid = sv;
      o.send_target = tgt;
      o.send_byte = sb;
      return o;
   endfunction

   function automatic stimulus_row_type entry(input logic [1:0] kind, input logic [3:0] port,
                                              input logic [7:0] wb, input logic [7:0] hb,
                                              input logic [5:0] links, input logic pin,
                                              input rsp_payload_type rsp);
      stimulus_row_type e;
      e.req.kind = kind;
      e.req.port = port;
      e.req.write_byte = wb;
      e.req.host_byte = hb;
      {e.req.tty_link, e.req.tty_rx_avail, e.req.crt_rx_avail,
       e.req.tape_link, e.req.tape_rx_avail, e.req.tape_tx_space} = links;
      e.pinned = pin;
      e.rsp = rsp;
      return e;
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      int              pick;
      pick = $urandom_range(0, 99);
      r.write_byte = 8'($urandom);
      r.host_byte = $urandom_range(0, 1) ? 8'($urandom_range(8'h5f, 8'h7c)) : 8'($urandom);
      r.tty_link = ($urandom_range(0, 7) != 0);
      r.tty_rx_avail = 1'($urandom);
      r.crt_rx_avail = 1'($urandom);
      r.tape_link = ($urandom_range(0, 7) != 0);
      r.tape_rx_avail = 1'($urandom);
      r.tape_tx_space = 1'($urandom);
      r.port = 4'($urandom_range(0, 8));
      if (pick < 30) begin
         r.kind = KIND_TICK;
      end else if (pick < 55) begin
         r.kind = KIND_READ;
         if ($urandom_range(0, 9) == 0) r.port = 4'($urandom_range(9, 15));
      end else if (pick < 97) begin
         r.kind = KIND_WRITE;
         case ($urandom_range(0, 9))
            0: begin
               r.port = PORT_INT;
               r.write_byte = {1'($urandom_range(0, 3) != 0), 7'($urandom) & 7'($urandom)};
            end
            1, 2: begin
               r.port = $urandom_range(0, 1) ? PORT_TTY_STAT : PORT_CRT_STAT;
               if ($urandom_range(0, 7) != 0) r.write_byte[CMD_RESET] = 1'b0;
               if ($urandom_range(0, 3) != 0) begin
                  r.write_byte[CMD_TXEN] = 1'b1;
                  r.write_byte[CMD_RXEN] = 1'b1;
               end
            end
            3: r.port = 4'($urandom_range(0, 15));
            default: begin
               case ($urandom_range(0, 3))
                  0: r.port = PORT_TTY_DATA;
                  1: r.port = PORT_CRT_DATA;
                  2: r.port = PORT_TAPE_DATA;
                  default: r.port = PORT_LPT_DATA;
               endcase
               case ($urandom_range(0, 7))
                  0: r.write_byte = BYTE_NUL;
                  1: r.write_byte = ~BYTE_CR;
                  2: r.write_byte = ~BYTE_NUL;
                  default: ;
               endcase
            end
         endcase
      end else begin
         r.kind = KIND_NONE;
         r.port = 4'($urandom);
      end
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t ns: %s mismatch, expected 0x%02h actual 0x%02h",
                  $time, field, want, got);
      end
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_request(input req_payload_type r, input logic pin,
                               input rsp_payload_type pinned);
      if (sender_idling && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_ch.payload <= r;
      req_ch.valid <= 1'b1;
      pinned_flag = pin;
      pinned_rsp = pinned;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic set_options(input logic [5:0] opts);
      int i;
      for (i = 0; i < OPTION_COUNT; i++) begin
         csr_index <= 3'(i);
         csr_write_data <= opts[i];
         csr_write_enable <= 1'b1;
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
      tty_st.upper = opts[CFG_TTY_UPPER];
      tty_st.strip = opts[CFG_TTY_STRIP];
      tty_st.skip = opts[CFG_TTY_SKIP];
      crt_st.upper = opts[CFG_CRT_UPPER];
      crt_st.strip = opts[CFG_CRT_STRIP];
      crt_st.skip = opts[CFG_CRT_SKIP];
   endtask

   always @(posedge clock) begin : response_check
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (expected_q.size() == 0) begin
            failures++;
            $display("%0t ns: unexpected transaction, actual 0x%05h", $time, got);
         end else begin
            want = expected_q.pop_front();
            compare_field("read_byte", want.read_byte, got.read_byte);
            compare_field("irq", 8'(want.irq), 8'(got.irq));
            compare_field("send_valid", 8'(want.send_valid), 8'(got.send_valid));
            compare_field("send_target", 8'(want.send_target), 8'(got.send_target));
            compare_field("send_byte", want.send_byte, got.send_byte);
         end
      end
      if (!reset && req_ch.valid && req_ch.ready) begin
         want = predict_response(req_ch.payload);
         expected_q.push_back(pinned_flag ? pinned_rsp : want);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : rsp_sink
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left = $urandom_range(1, 5) - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [5:0] phase_options [PHASE_COUNT];
      int         phase;
      int         n;
      stimulus_row_type row;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      failures = 0;
      stall_cycles = 0;
      sender_idling = 1'b1;
      receiver_idling = 1'b1;
      long_hold_pending = 1'b0;
      pinned_flag = 1'b0;
      pinned_rsp = '0;
      exp_int_flags = '0;
      tty_st = '0;
      crt_st = '0;
      reader_rdy = 1'b0;
      punch_rdy = 1'b0;
      printer_rdy = 1'b0;
      reader_byte = '0;
      phase_options = '{6'h3f, 6'h15, 6'h2a, 6'h00, 6'($urandom)};

      directed_rows.push_back(entry(KIND_READ, PORT_INT, 8'h00, 8'h00, LINKS_ALL, 1'b1,
                                    rsp_of(8'h00, 1'b0, 1'b0, TARGET_TTY, 8'h00)));
      directed_rows.push_back(entry(KIND_READ, PORT_TTY_STAT, 8'h00, 8'h00, LINKS_NONE, 1'b1,
                                    rsp_of(STAT_BASE, 1'b0, 1'b0, TARGET_TTY, 8'h00)));
      directed_rows.push_back(entry(KIND_NONE, 4'hf, 8'hff, 8'hff, LINKS_ALL, 1'b1,
                                    rsp_of(8'h00, 1'b0, 1'b0, TARGET_TTY, 8'h00)));
      directed_rows.push_back(entry(KIND_READ, 4'hf, 8'hff, 8'hff, LINKS_ALL, 1'b1,
                                    rsp_of(8'h00, 1'b0, 1'b0, TARGET_TTY, 8'h00)));
      // mode bytes are swallowed, the next write is the command
      directed_rows.push_back(entry(KIND_WRITE, PORT_TTY_STAT, 8'h4e, 8'h00, LINKS_HOST, 1'b1,
                                    rsp_of(8'h00, 1'b0, 1'b0, TARGET_TTY, 8'h00)));
      directed_rows.push_back(entry(KIND_WRITE, PORT_TTY_STAT, 8'h37, 8'h00, LINKS_HOST,
                                    1'b0, '0));
      directed_rows.push_back(entry(KIND_WRITE, PORT_CRT_STAT, 8'hff, 8'h00, LINKS_HOST,
                                    1'b0, '0));
      directed_rows.push_back(entry(KIND_WRITE, PORT_CRT_STAT, 8'h05, 8'h00, LINKS_HOST,
                                    1'b0, '0));
      directed_rows.push_back(entry(KIND_TICK, PORT_INT, 8'h00, 8'h00, LINKS_ALL, 1'b1,
                                    rsp_of(8'h00, 1'b0, 1'b0, TARGET_TTY, 8'h00)));
      directed_rows.push_back(entry(KIND_WRITE, PORT_INT, 8'h80, 8'h00, LINKS_HOST, 1'b1,
                                    rsp_of(8'h00, 1'b1, 1'b0, TARGET_TTY, 8'h00)));
      directed_rows.push_back(entry(KIND_READ, PORT_INT, 8'h00, 8'h00, LINKS_HOST, 1'b1,
                                    rsp_of(8'h7f, 1'b1, 1'b0, TARGET_TTY, 8'h00)));
      directed_rows.push_back(entry(KIND_READ, PORT_TTY_DATA, 8'h00, 8'h61, LINKS_HOST,
                                    1'b0, '0));
      directed_rows.push_back(entry(KIND_WRITE, PORT_TTY_DATA, 8'hff, 8'h00, LINKS_HOST,
                                    1'b0, '0));
      // complement is CR, nothing goes out
      directed_rows.push_back(entry(KIND_WRITE, PORT_LPT_DATA, 8'hf2, 8'h00, LINKS_HOST,
                                    1'b0, '0));
      directed_rows.push_back(entry(KIND_WRITE, PORT_TAPE_DATA, 8'h5a, 8'h00, LINKS_HOST,
                                    1'b0, '0));
      directed_rows.push_back(entry(KIND_READ, PORT_TAPE_DATA, 8'h00, 8'ha5, LINKS_HOST,
                                    1'b0, '0));
      directed_rows.push_back(entry(KIND_TICK, PORT_INT, 8'h00, 8'h00, LINKS_NONE, 1'b0, '0));
      directed_rows.push_back(entry(KIND_WRITE, PORT_LPT_DATA, 8'h41, 8'h00, LINKS_HOST,
                                    1'b0, '0));
      directed_rows.push_back(entry(KIND_READ, PORT_CRT_DATA, 8'h00, 8'h00, LINKS_NONE,
                                    1'b0, '0));
      directed_rows.push_back(entry(KIND_WRITE, PORT_CRT_DATA, 8'h00, 8'h00, LINKS_NONE,
                                    1'b0, '0));
      directed_rows.push_back(entry(KIND_WRITE, PORT_TTY_STAT, 8'h40, 8'h00, LINKS_HOST,
                                    1'b0, '0));
      directed_rows.push_back(entry(KIND_WRITE, PORT_CRT_STAT, 8'h00, 8'h00, LINKS_HOST,
                                    1'b0, '0));
      directed_rows.push_back(entry(KIND_WRITE, PORT_INT, 8'h7f, 8'h00, LINKS_HOST, 1'b1,
                                    rsp_of(8'h00, 1'b0, 1'b0, TARGET_TTY, 8'h00)));
      directed_rows.push_back(entry(KIND_READ, PORT_TTY_DATA, 8'h00, 8'hee, LINKS_HOST,
                                    1'b0, '0));
      directed_rows.push_back(entry(KIND_READ, PORT_LPT_STAT, 8'h00, 8'h00, LINKS_HOST,
                                    1'b0, '0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_request(row.req, row.pinned, row.rsp);
      end
      drain_responses();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         set_options(phase_options[phase]);
         sender_idling = (phase < PHASE_COUNT - 1);
         receiver_idling = (phase < PHASE_COUNT - 1);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 1 && n == 100) long_hold_pending = 1'b1;
            send_request(random_request(), 1'b0, '0);
         end
         drain_responses();
      end

      repeat (4) @(posedge clock);
      if (failures == 0 && expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/mio_pkg.sv
rtl/mio_stream_if.sv
rtl/mio_usart.sv
rtl/monitor_io_ports_with_interrupts.sv
dv/monitor_io_ports_with_interrupts_test.sv
